// ===== src/nfcs_pkg.sv =====
package nfcs_pkg;

    localparam int ADDR_BITS = 19;
    localparam int DATA_BITS = 16;

    // Request types on the input channel.
    localparam logic [1:0] REQ_ERASE   = 2'd0;
    localparam logic [1:0] REQ_PROGRAM = 2'd1;
    localparam logic [1:0] REQ_READ_ID = 2'd2;
    localparam logic [1:0] REQ_RESP    = 2'd3;

    // Bus operations on the output channel.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    // Completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    // Output sequences that one request can produce.
    localparam logic [2:0] SQ_DONE    = 3'd0;
    localparam logic [2:0] SQ_ID_DONE = 3'd1;
    localparam logic [2:0] SQ_TIMEOUT = 3'd2;
    localparam logic [2:0] SQ_POLL    = 3'd3;
    localparam logic [2:0] SQ_ERASE   = 3'd4;
    localparam logic [2:0] SQ_PROGRAM = 3'd5;
    localparam logic [2:0] SQ_READ_ID = 3'd6;

    localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK1 = ADDR_BITS'('h555);
    localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK2 = ADDR_BITS'('h2AA);
    localparam logic [ADDR_BITS-1:0] ADDR_ZERO    = '0;

    localparam logic [DATA_BITS-1:0] CMD_UNLOCK1   = DATA_BITS'('hAA);
    localparam logic [DATA_BITS-1:0] CMD_UNLOCK2   = DATA_BITS'('h55);
    localparam logic [DATA_BITS-1:0] READ_ARRAY    = DATA_BITS'('hF0);
    localparam logic [DATA_BITS-1:0] CMD_AUTOSEL   = DATA_BITS'('h90);
    localparam logic [DATA_BITS-1:0] PROGRAM_SETUP = DATA_BITS'('hA0);
    localparam logic [DATA_BITS-1:0] ERASE_SETUP   = DATA_BITS'('h80);
    localparam logic [DATA_BITS-1:0] SECTOR_ERASE  = DATA_BITS'('h30);
    localparam logic [DATA_BITS-1:0] ERASED_WORD   = {DATA_BITS{1'b1}};

    localparam logic [ADDR_BITS:0] DEVICE_WORDS_RESET = (ADDR_BITS+1)'(1 << ADDR_BITS);

    typedef struct packed {
        logic [2:0]           kind;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic [DATA_BITS-1:0] maker;
        logic [1:0]           status;
    } t_seq;

endpackage

// ===== src/nor_flash_command_sequencer_top.sv =====
// Command sequencer for a 16-bit NOR flash with the unlock command set.
// Input channel (i_in_valid / o_in_ready): one request per item, either an
// erase, a word program, an identifier read or the data of a flash read.
// Output channel (o_out_valid / i_out_ready): one result per flash bus access
// (write or read), plus a completion carrying the status where an operation
// ends; o_last marks the final result of each request.
// Configuration channel (i_cfg_valid / o_cfg_ready): device size in words,
// always ready; write it only while no request is in flight.
// Timing: the first result of a request is valid in the cycle after it is
// accepted. Results leave one per cycle while the receiver takes them; a
// request gives 7 results for an erase, 5 for a program, 4 for each of the
// first two identifier steps and 2 for the last, 1 or 2 for a status poll and
// 1 for a rejected request. The output sequencer sets this rate; the next
// request is accepted in the cycle that its last result is taken.
// When the receiver stalls, the current result holds and no further request
// is accepted. Reset returns the block to idle, clears the buffer skip flag
// and restores the full device size.
module nor_flash_command_sequencer_top
    import nfcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [ADDR_BITS-1:0] i_word_addr,
    input  logic [DATA_BITS-1:0] i_write_data,
    input  logic [DATA_BITS-1:0] i_read_data,
    input  logic                 i_final_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_bus_op,
    output logic [ADDR_BITS-1:0] o_bus_addr,
    output logic [DATA_BITS-1:0] o_bus_data,
    output logic [DATA_BITS-1:0] o_maker_id,
    output logic [DATA_BITS-1:0] o_device_id,
    output logic [1:0]           o_status,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ADDR_BITS:0]   i_cfg_device_words
);

    t_seq seq;
    logic busy;
    logic accept;
    logic take;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = busy;
    assign take        = busy && i_out_ready;
    assign o_in_ready  = !busy || (i_out_ready && o_last);
    assign accept      = i_in_valid && o_in_ready;

    nfcs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_word_addr  (i_word_addr),
        .i_write_data (i_write_data),
        .i_read_data  (i_read_data),
        .i_final_word (i_final_word),
        .i_cfg_write  (i_cfg_valid),
        .i_cfg_words  (i_cfg_device_words),
        .o_seq        (seq)
    );

    nfcs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_seq       (seq),
        .i_take      (take),
        .o_busy      (busy),
        .o_bus_op    (o_bus_op),
        .o_bus_addr  (o_bus_addr),
        .o_bus_data  (o_bus_data),
        .o_maker_id  (o_maker_id),
        .o_device_id (o_device_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    a_ready_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || (i_out_ready && o_last)))
        else $error("input taken while results are still pending");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    a_sequence_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("result sequence ended without a last result");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bus_op == OP_DONE) |-> o_last)
        else $error("completion not marked as last result");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_bus_op == OP_DONE))
        else $error("nonzero status on a bus access");

endmodule

// ===== src/nfcs_ctrl.sv =====
module nfcs_ctrl
    import nfcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_req_type,
    input  logic [ADDR_BITS-1:0] i_word_addr,
    input  logic [DATA_BITS-1:0] i_write_data,
    input  logic [DATA_BITS-1:0] i_read_data,
    input  logic                 i_final_word,
    input  logic                 i_cfg_write,
    input  logic [ADDR_BITS:0]   i_cfg_words,
    output t_seq                 o_seq
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_POLL     = 2'd1;
    localparam logic [1:0] PH_ID_MAKER = 2'd2;
    localparam logic [1:0] PH_ID_DEV   = 2'd3;

    localparam logic [1:0] K_ERASE      = 2'd0;
    localparam logic [1:0] K_PROG       = 2'd1;
    localparam logic [1:0] K_PROG_FINAL = 2'd2;
    localparam logic [1:0] K_ID         = 2'd3;

    logic [ADDR_BITS:0]   r_device_words;
    logic [1:0]           r_phase, n_phase;
    logic [1:0]           r_op_kind, n_op_kind;
    logic [ADDR_BITS-1:0] r_target_addr, n_target_addr;
    logic [DATA_BITS-1:0] r_expected, n_expected;
    logic [DATA_BITS-1:0] r_maker, n_maker;
    logic                 r_skip, n_skip;
    logic                 out_of_range;

    assign out_of_range = {1'b0, i_word_addr} >= r_device_words;

    always_comb begin
        n_phase       = r_phase;
        n_op_kind     = r_op_kind;
        n_target_addr = r_target_addr;
        n_expected    = r_expected;
        n_maker       = r_maker;
        n_skip        = r_skip;
        o_seq         = '{kind: SQ_DONE, addr: '0, data: '0, maker: '0, status: ST_REJECT};

        if (i_req_type == REQ_RESP) begin
            unique case (r_phase)
                PH_POLL: begin
                    if (i_read_data[7] == r_expected[7]) begin
                        o_seq.status = ST_OK;
                        n_phase = PH_IDLE;
                    end else if (i_read_data[5]) begin
                        o_seq.kind = SQ_TIMEOUT;
                        o_seq.status = ST_TIMEOUT;
                        if (r_op_kind == K_PROG) begin
                            n_skip = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end else begin
                        o_seq.kind = SQ_POLL;
                        o_seq.addr = r_target_addr;
                    end
                end
                PH_ID_MAKER: begin
                    n_maker    = i_read_data;
                    o_seq.kind = SQ_READ_ID;
                    o_seq.addr = ADDR_BITS'(1);
                    n_phase    = PH_ID_DEV;
                end
                PH_ID_DEV: begin
                    o_seq.kind  = SQ_ID_DONE;
                    o_seq.data  = i_read_data;
                    o_seq.maker = r_maker;
                    o_seq.status = ST_OK;
                    n_phase = PH_IDLE;
                end
                default: begin
                    // A response with no sequence running is rejected.
                end
            endcase
        end else if (r_phase != PH_IDLE) begin
            // Busy: the request is rejected and the state kept.
        end else begin
            unique case (i_req_type)
                REQ_ERASE: begin
                    if (out_of_range) begin
                        o_seq.status = ST_RANGE;
                    end else begin
                        o_seq.kind    = SQ_ERASE;
                        o_seq.addr    = i_word_addr;
                        n_op_kind     = K_ERASE;
                        n_target_addr = i_word_addr;
                        n_expected    = ERASED_WORD;
                        n_phase       = PH_POLL;
                    end
                end
                REQ_PROGRAM: begin
                    if (r_skip) begin
                        if (i_final_word) begin
                            n_skip = 1'b0;
                        end
                    end else if (out_of_range) begin
                        o_seq.status = ST_RANGE;
                        if (!i_final_word) begin
                            n_skip = 1'b1;
                        end
                    end else begin
                        o_seq.kind    = SQ_PROGRAM;
                        o_seq.addr    = i_word_addr;
                        o_seq.data    = i_write_data;
                        n_op_kind     = i_final_word ? K_PROG_FINAL : K_PROG;
                        n_target_addr = i_word_addr;
                        n_expected    = i_write_data;
                        n_phase       = PH_POLL;
                    end
                end
                default: begin
                    o_seq.kind = SQ_READ_ID;
                    o_seq.addr = ADDR_ZERO;
                    n_op_kind  = K_ID;
                    n_phase    = PH_ID_MAKER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_words <= DEVICE_WORDS_RESET;
            r_phase        <= PH_IDLE;
            r_op_kind      <= K_ERASE;
            r_target_addr  <= '0;
            r_expected     <= '0;
            r_maker        <= '0;
            r_skip         <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_device_words <= i_cfg_words;
            end
            if (i_accept) begin
                r_phase       <= n_phase;
                r_op_kind     <= n_op_kind;
                r_target_addr <= n_target_addr;
                r_expected    <= n_expected;
                r_maker       <= n_maker;
                r_skip        <= n_skip;
            end
        end
    end

endmodule

// ===== src/nfcs_emit.sv =====
module nfcs_emit
    import nfcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_seq                 i_seq,
    input  logic                 i_take,
    output logic                 o_busy,
    output logic [1:0]           o_bus_op,
    output logic [ADDR_BITS-1:0] o_bus_addr,
    output logic [DATA_BITS-1:0] o_bus_data,
    output logic [DATA_BITS-1:0] o_maker_id,
    output logic [DATA_BITS-1:0] o_device_id,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    t_seq       r_seq;
    logic       r_busy;
    logic [2:0] r_step;

    assign o_busy = r_busy;

    // Unlock-pair command writes ending in a read, poll reads and completions.
    always_comb begin
        o_bus_op    = OP_WRITE;
        o_bus_addr  = ADDR_ZERO;
        o_bus_data  = '0;
        o_maker_id  = '0;
        o_device_id = '0;
        o_status    = ST_OK;
        o_last      = 1'b0;
        unique case (r_seq.kind)
            SQ_DONE: begin
                o_bus_op = OP_DONE;
                o_status = r_seq.status;
                o_last   = 1'b1;
            end
            SQ_ID_DONE, SQ_TIMEOUT: begin
                if (r_step == 3'd0) begin
                    o_bus_data = READ_ARRAY;
                end else begin
                    o_bus_op = OP_DONE;
                    o_status = r_seq.status;
                    o_last   = 1'b1;
                    if (r_seq.kind == SQ_ID_DONE) begin
                        o_maker_id  = r_seq.maker;
                        o_device_id = r_seq.data;
                    end
                end
            end
            SQ_POLL: begin
                o_bus_op   = OP_READ;
                o_bus_addr = r_seq.addr;
                o_last     = 1'b1;
            end
            SQ_ERASE: begin
                case (r_step)
                    3'd0, 3'd3: begin
                        o_bus_addr = ADDR_UNLOCK1;
                        o_bus_data = CMD_UNLOCK1;
                    end
                    3'd1, 3'd4: begin
                        o_bus_addr = ADDR_UNLOCK2;
                        o_bus_data = CMD_UNLOCK2;
                    end
                    3'd2: begin
                        o_bus_addr = ADDR_UNLOCK1;
                        o_bus_data = ERASE_SETUP;
                    end
                    3'd5: begin
                        o_bus_addr = r_seq.addr;
                        o_bus_data = SECTOR_ERASE;
                    end
                    default: begin
                        o_bus_op   = OP_READ;
                        o_bus_addr = r_seq.addr;
                        o_last     = 1'b1;
                    end
                endcase
            end
            default: begin
                // Program and identifier read share the unlock prefix.
                case (r_step)
                    3'd0: begin
                        o_bus_addr = ADDR_UNLOCK1;
                        o_bus_data = CMD_UNLOCK1;
                    end
                    3'd1: begin
                        o_bus_addr = ADDR_UNLOCK2;
                        o_bus_data = CMD_UNLOCK2;
                    end
                    3'd2: begin
                        o_bus_addr = ADDR_UNLOCK1;
                        o_bus_data = (r_seq.kind == SQ_PROGRAM) ? PROGRAM_SETUP : CMD_AUTOSEL;
                    end
                    3'd3: begin
                        o_bus_addr = r_seq.addr;
                        if (r_seq.kind == SQ_PROGRAM) begin
                            o_bus_data = r_seq.data;
                        end else begin
                            o_bus_op = OP_READ;
                            o_last   = 1'b1;
                        end
                    end
                    default: begin
                        o_bus_op   = OP_READ;
                        o_bus_addr = r_seq.addr;
                        o_last     = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (i_take) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seq <= i_seq;
        end
    end

endmodule
